### rtl/rbma_pkg.sv
// Shared types, constants and helper functions of the read buffer map allocator.
package rbma_pkg;

    localparam int ENTRIES_PER_MAP = 8;
    localparam int MAP_COUNT       = 2;

    localparam int ENTRY_W    = 4;
    localparam int ENABLE_POS = 3;
    localparam int MAX_SLOT   = 3;
    localparam int MAX_VCHAN  = 3;
    localparam int MAP_W      = ENTRY_W * ENTRIES_PER_MAP;
    localparam int MAP_REGS   = 2;
    localparam int IDX_W      = (ENTRIES_PER_MAP > 1) ? $clog2(ENTRIES_PER_MAP) : 1;
    localparam int CNT_W      = $clog2(ENTRIES_PER_MAP + 1);
    localparam int CMP_W      = (CNT_W > 4) ? CNT_W : 4;
    localparam int WORD_W     = 32;
    localparam int FREED_W    = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_COUNT_OWNED = 3'd0,
        OP_COUNT_FREE  = 3'd1,
        OP_ALLOC       = 3'd2,
        OP_FREE        = 3'd3,
        OP_RAW_READ    = 3'd4,
        OP_RAW_WRITE   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_PARTIAL = 2'd1,
        STAT_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_RAW,
        KIND_INVALID,
        KIND_SCAN
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_kind                kind;
        t_op                  op;
        logic                 reg_sel;
        logic                 present;
        logic [ENTRY_W-1:0]   owned;
        logic [3:0]           amount;
        logic [WORD_W-1:0]    write_word;
    } t_cmd;

    typedef struct packed {
        logic [3:0]         count;
        t_status            status;
        logic [FREED_W-1:0] freed_mask;
        logic [WORD_W-1:0]  read_word;
    } t_result;

    function automatic logic [WORD_W-1:0] map_to_word(input logic [MAP_W-1:0] map);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (i < MAP_W) w[i] = map[i];
        end
        return w;
    endfunction

    function automatic logic [MAP_W-1:0] word_to_map(input logic [WORD_W-1:0] w);
        logic [MAP_W-1:0] map;
        map = '0;
        for (int i = 0; i < MAP_W; i++) begin
            if (i < WORD_W) map[i] = w[i];
        end
        return map;
    endfunction

    function automatic logic [FREED_W-1:0] freed_low(input logic [ENTRIES_PER_MAP-1:0] f);
        logic [FREED_W-1:0] m;
        m = '0;
        for (int i = 0; i < FREED_W; i++) begin
            if (i < ENTRIES_PER_MAP) m[i] = f[i];
        end
        return m;
    endfunction

    function automatic logic [3:0] sat_count(input logic [CNT_W-1:0] n);
        if (CMP_W'(n) > CMP_W'(15)) return 4'hf;
        return 4'(n);
    endfunction

endpackage

### rtl/read_buffer_map_allocator_top.sv
// Top level: decoder, command queue and execution engine of the read buffer map allocator.
// The engine dequeues each word; for valid count, allocate and free it scans the map one
// entry per cycle, then registers the result (writing the map back for allocate and free)
// once the output is not stalled. Raw, invalid and unused ops skip the scan. A new word is
// taken only after the last result is registered; a two-word queue decouples input.
// Synchronous active-low reset empties the queue and output and clears both maps to zero.
module read_buffer_map_allocator_top import rbma_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [2:0]  i_slot,
    input  logic [2:0]  i_vchan,
    input  logic [3:0]  i_amount,
    input  logic        i_map_index,
    input  logic [31:0] i_write_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_count,
    output logic [1:0]  o_status,
    output logic [7:0]  o_freed_mask,
    output logic [31:0] o_read_word
);

    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    queue_full;
    logic    head_valid;
    logic    pop;
    t_result result;

    rbma_front u_front (
        .i_in_valid   (i_in_valid),
        .i_opcode     (i_opcode),
        .i_slot       (i_slot),
        .i_vchan      (i_vchan),
        .i_amount     (i_amount),
        .i_map_index  (i_map_index),
        .i_write_word (i_write_word),
        .i_queue_full (queue_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    rbma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    rbma_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_count      = result.count;
    assign o_status     = result.status;
    assign o_freed_mask = result.freed_mask;
    assign o_read_word  = result.read_word;

endmodule

### rtl/rbma_front.sv
// Request decoder: validates slot and channel and builds the command word.
module rbma_front import rbma_pkg::*; (
    input  logic        i_in_valid,
    input  logic [2:0]  i_opcode,
    input  logic [2:0]  i_slot,
    input  logic [2:0]  i_vchan,
    input  logic [3:0]  i_amount,
    input  logic        i_map_index,
    input  logic [31:0] i_write_word,
    input  logic        i_queue_full,
    output logic        o_in_stall,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic slot_reg;
    logic slot_present;
    logic bad;

    assign slot_reg     = i_slot[0];
    assign slot_present = int'(slot_reg) < MAP_COUNT;
    assign bad          = (int'(i_slot) > MAX_SLOT) ||
                          ((i_opcode != OP_COUNT_FREE) && (int'(i_vchan) > MAX_VCHAN));

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = OP_COUNT_OWNED;
        o_cmd.kind       = KIND_NOP;
        o_cmd.amount     = i_amount;
        o_cmd.write_word = i_write_word;
        o_cmd.owned      = {1'b1, i_vchan[1:0], i_slot[1]};
        if (i_opcode == OP_RAW_READ || i_opcode == OP_RAW_WRITE) begin
            o_cmd.kind    = KIND_RAW;
            o_cmd.op      = t_op'(i_opcode);
            o_cmd.reg_sel = i_map_index;
            o_cmd.present = int'(i_map_index) < MAP_COUNT;
        end else if (i_opcode <= OP_FREE) begin
            o_cmd.kind    = bad ? KIND_INVALID : KIND_SCAN;
            o_cmd.op      = t_op'(i_opcode);
            o_cmd.reg_sel = slot_present ? slot_reg : 1'b0;
            o_cmd.present = 1'b1;
        end
    end

endmodule

### rtl/rbma_queue.sv
// Two-entry command queue between decoder and execution engine.
module rbma_queue import rbma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_data [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_data[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (do_pop) r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (i_push && !do_pop) r_cnt <= r_cnt + QCNT_W'(1);
            else if (!i_push && do_pop) r_cnt <= r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_data[r_wr_ptr] <= i_cmd;
    end

endmodule

### rtl/rbma_back.sv
// Execution engine: holds the map registers, scans entries and drives the result word.
module rbma_back import rbma_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_result
);

    t_state                     r_state, n_state;
    t_cmd                       r_cmd, n_cmd;
    logic [MAP_W-1:0]           r_map, n_map;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [CNT_W-1:0]           r_n, n_n;
    logic [ENTRIES_PER_MAP-1:0] r_freed, n_freed;
    logic                       r_out_valid, n_out_valid;
    t_result                    r_result, n_result;
    logic [MAP_W-1:0]           r_maps [0:MAP_REGS-1];
    logic                       map_we;
    logic [ENTRY_W-1:0]         entry;
    logic                       below;

    assign entry       = r_map[ENTRY_W*r_idx +: ENTRY_W];
    assign below       = CMP_W'(r_n) < CMP_W'(r_cmd.amount);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_map       = r_map;
        n_idx       = r_idx;
        n_n         = r_n;
        n_freed     = r_freed;
        n_result    = r_result;
        n_out_valid = r_out_valid && i_out_stall;
        map_we      = 1'b0;
        o_cmd_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_n       = '0;
                    n_freed   = '0;
                    if (!i_cmd.present) n_map = '0;
                    else if (i_cmd.kind == KIND_RAW && i_cmd.op == OP_RAW_WRITE)
                        n_map = word_to_map(i_cmd.write_word);
                    else n_map = r_maps[i_cmd.reg_sel];
                    n_state = (i_cmd.kind == KIND_SCAN) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                unique case (r_cmd.op)
                    OP_COUNT_OWNED: begin
                        if (entry == r_cmd.owned) n_n = r_n + CNT_W'(1);
                    end
                    OP_COUNT_FREE: begin
                        if (!entry[ENABLE_POS]) n_n = r_n + CNT_W'(1);
                    end
                    OP_ALLOC: begin
                        if (below && !entry[ENABLE_POS]) begin
                            n_map[ENTRY_W*r_idx +: ENTRY_W] = r_cmd.owned;
                            n_n = r_n + CNT_W'(1);
                        end
                    end
                    OP_FREE: begin
                        if (below && entry == r_cmd.owned) begin
                            n_map[ENTRY_W*r_idx + ENABLE_POS] = 1'b0;
                            n_freed[r_idx] = 1'b1;
                            n_n = r_n + CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                if (r_idx == IDX_W'(ENTRIES_PER_MAP - 1)) n_state = ST_FINISH;
                else n_idx = r_idx + IDX_W'(1);
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    n_result    = '0;
                    unique case (r_cmd.kind)
                        KIND_NOP: begin
                        end
                        KIND_RAW: begin
                            n_result.read_word = map_to_word(r_map);
                            map_we = r_cmd.present && (r_cmd.op == OP_RAW_WRITE);
                        end
                        KIND_INVALID: begin
                            n_result.status    = STAT_INVALID;
                            n_result.read_word = map_to_word(r_map);
                        end
                        KIND_SCAN: begin
                            n_result.count      = sat_count(r_n);
                            n_result.freed_mask = freed_low(r_freed);
                            n_result.read_word  = map_to_word(r_map);
                            if (r_cmd.op == OP_ALLOC || r_cmd.op == OP_FREE) begin
                                map_we = 1'b1;
                                if (below) n_result.status = STAT_PARTIAL;
                            end
                        end
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAP_REGS; i++) r_maps[i] <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (map_we) r_maps[r_cmd.reg_sel] <= r_map;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_map    <= n_map;
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_freed  <= n_freed;
        r_result <= n_result;
    end

endmodule

### rtl/rbma_checker.sv
// Port-level assertions for the read buffer map allocator and their bind.
module rbma_checker import rbma_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_count,
    input logic [1:0]  o_status,
    input logic [7:0]  o_freed_mask,
    input logic [31:0] o_read_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_count) && $stable(o_status) &&
            $stable(o_freed_mask) && $stable(o_read_word))
        else $error("stalled output word changed");

    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_INVALID) |-> (o_count == 4'd0) &&
            (o_freed_mask == 8'd0))
        else $error("invalid request reported work");

    a_freed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_freed_mask != 8'd0) |-> ($countones(o_freed_mask) == int'(o_count)))
        else $error("freed mask disagrees with count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind read_buffer_map_allocator_top rbma_checker u_rbma_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_count      (o_count),
    .o_status     (o_status),
    .o_freed_mask (o_freed_mask),
    .o_read_word  (o_read_word)
);

### bench/read_buffer_map_allocator_top_tb.sv
`timescale 1ns / 1ps
// Testbench of the read buffer map allocator with directed and random requests.
module read_buffer_map_allocator_top_tb;
    import rbma_pkg::*;

    localparam int          IDLE_LIMIT   = 4000;
    localparam int          RANDOM_WORDS = 1725;
    localparam int          DRAIN_CYCLES = 30;
    localparam logic [2:0]  OP_UNUSED_LO = 3'd6;
    localparam logic [2:0]  OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [2:0]  vchan;
        logic [3:0]  amount;
        logic        map_index;
        logic [31:0] write_word;
    } t_map_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_opcode;
    logic [2:0]  i_slot;
    logic [2:0]  i_vchan;
    logic [3:0]  i_amount;
    logic        i_map_index;
    logic [31:0] i_write_word;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_count;
    logic [1:0]  o_status;
    logic [7:0]  o_freed_mask;
    logic [31:0] o_read_word;

    t_map_request pending_words[$];
    t_result      expected_results[$];
    logic [31:0]  map_shadow [MAP_REGS];

    bit in_taken;
    int total_words;
    int accepted_words;
    int checked_results;
    int mismatches;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_left;
    int stall_mode;
    int mode_left;
    int short_fills;
    int invalid_requests;
    int op_hits [8];

    read_buffer_map_allocator_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_slot       (i_slot),
        .i_vchan      (i_vchan),
        .i_amount     (i_amount),
        .i_map_index  (i_map_index),
        .i_write_word (i_write_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_count      (o_count),
        .o_status     (o_status),
        .o_freed_mask (o_freed_mask),
        .o_read_word  (o_read_word)
    );

    function automatic t_result apply_map_request(input t_map_request req);
        t_result     r;
        logic [31:0] m;
        logic [3:0]  owned;
        logic [3:0]  e;
        int          n;
        r = '0;
        if (req.op > OP_RAW_WRITE) return r;
        if (req.op >= OP_RAW_READ) begin
            if (req.op == OP_RAW_WRITE) map_shadow[req.map_index] = req.write_word;
            r.read_word = map_shadow[req.map_index];
            return r;
        end
        m = map_shadow[req.slot[0]];
        r.read_word = m;
        if (req.slot > MAX_SLOT || (req.op != OP_COUNT_FREE && req.vchan > MAX_VCHAN)) begin
            r.status = STAT_INVALID;
            return r;
        end
        owned = {1'b1, req.vchan[1:0], req.slot[1]};
        n = 0;
        for (int i = 0; i < ENTRIES_PER_MAP; i++) begin
            e = m[4*i +: 4];
            case (req.op)
                OP_COUNT_OWNED: if (e == owned) n++;
                OP_COUNT_FREE: if (!e[ENABLE_POS]) n++;
                OP_ALLOC: if (n < req.amount && !e[ENABLE_POS]) begin
                    m[4*i +: 4] = owned;
                    n++;
                end
                default: if (n < req.amount && e == owned) begin
                    m[4*i + ENABLE_POS] = 1'b0;
                    r.freed_mask[i] = 1'b1;
                    n++;
                end
            endcase
        end
        if (req.op >= OP_ALLOC) begin
            map_shadow[req.slot[0]] = m;
            if (n < req.amount) r.status = STAT_PARTIAL;
        end
        r.count = (n > 15) ? 4'hf : 4'(n);
        r.read_word = map_shadow[req.slot[0]];
        return r;
    endfunction

    task automatic queue_word(input logic [2:0] op, input logic [2:0] slot,
                              input logic [2:0] vchan, input logic [3:0] amount,
                              input logic map_index, input logic [31:0] write_word);
        pending_words.push_back({op, slot, vchan, amount, map_index, write_word});
        total_words++;
    endtask

    function automatic t_map_request random_word();
        t_map_request req;
        int unsigned  pick;
        pick = $urandom_range(0, 99);
        req.slot = 3'($urandom_range(0, MAX_SLOT));
        req.vchan = 3'($urandom_range(0, MAX_VCHAN));
        req.amount = ($urandom_range(0, 2) != 0) ? 4'($urandom_range(0, 4))
                                                 : 4'($urandom_range(0, ENTRIES_PER_MAP));
        req.map_index = 1'($urandom);
        req.write_word = $urandom;
        if (pick < 60) begin
            req.op = ($urandom_range(0, 2) != 0) ? 3'($urandom_range(OP_ALLOC, OP_FREE))
                                                 : 3'($urandom_range(OP_COUNT_OWNED,
                                                                     OP_COUNT_FREE));
        end else if (pick < 72) begin
            req.op = OP_RAW_WRITE;
            case ($urandom_range(0, 3))
                0: req.write_word = '0;
                1: req.write_word = $urandom & $urandom;
                default: req.write_word = $urandom;
            endcase
        end else if (pick < 80) begin
            req.op = OP_RAW_READ;
        end else begin
            req.op = 3'($urandom_range(OP_COUNT_OWNED, OP_UNUSED_HI));
            req.slot = 3'($urandom);
            req.vchan = 3'($urandom);
            req.amount = 4'($urandom);
        end
        return req;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin : driver
        t_map_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold
        end else if (gap_left > 0 || pending_words.size() == 0) begin
            if (gap_left > 0) gap_left--;
            i_in_valid <= 1'b0;
        end else begin
            req = pending_words.pop_front();
            i_in_valid   <= 1'b1;
            i_opcode     <= req.op;
            i_slot       <= req.slot;
            i_vchan      <= req.vchan;
            i_amount     <= req.amount;
            i_map_index  <= req.map_index;
            i_write_word <= req.write_word;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (stall_mode == 1 && $urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
        end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result      got;
        t_result      want;
        t_map_request req;
        bit           moved;
        in_taken = 1'b0;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                got.count = o_count;
                got.status = t_status'(o_status);
                got.freed_mask = o_freed_mask;
                got.read_word = o_read_word;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word count=%0d status=%0d freed=%h read=%h",
                                 $realtime, got.count, got.status, got.freed_mask,
                                 got.read_word);
                end else begin
                    want = expected_results.pop_front();
                    checked_results++;
                    if (got.count !== want.count || got.status !== want.status ||
                        got.freed_mask !== want.freed_mask ||
                        got.read_word !== want.read_word) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch expected count=%0d status=%0d ",
                                      "freed=%h read=%h, got count=%0d status=%0d ",
                                      "freed=%h read=%h"},
                                     $realtime, want.count, want.status, want.freed_mask,
                                     want.read_word, got.count, got.status, got.freed_mask,
                                     got.read_word);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                in_taken = 1'b1;
                req = {i_opcode, i_slot, i_vchan, i_amount, i_map_index, i_write_word};
                want = apply_map_request(req);
                expected_results.push_back(want);
                accepted_words++;
                op_hits[req.op]++;
                if (want.status == STAT_PARTIAL) short_fills++;
                if (want.status == STAT_INVALID) invalid_requests++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_opcode = OP_COUNT_OWNED;
        i_slot = '0;
        i_vchan = '0;
        i_amount = '0;
        i_map_index = 1'b0;
        i_write_word = '0;
        i_out_stall = 1'b0;
        burst_left = 1;
        for (int r = 0; r < MAP_REGS; r++) map_shadow[r] = '0;

        queue_word(OP_COUNT_FREE,  3'd0, 3'd0, 4'd0,  1'b0, 32'h0);
        queue_word(OP_ALLOC,       3'd0, 3'd0, 4'd3,  1'b0, 32'h0);
        queue_word(OP_ALLOC,       3'd1, 3'd3, 4'd8,  1'b1, 32'h0);
        queue_word(OP_ALLOC,       3'd2, 3'd2, 4'd8,  1'b0, 32'h0);
        queue_word(OP_COUNT_OWNED, 3'd0, 3'd0, 4'd0,  1'b0, 32'h0);
        queue_word(OP_COUNT_OWNED, 3'd2, 3'd2, 4'd0,  1'b0, 32'h0);
        queue_word(OP_COUNT_FREE,  3'd3, 3'd7, 4'd0,  1'b0, 32'h0);
        queue_word(OP_FREE,        3'd0, 3'd0, 4'd2,  1'b0, 32'h0);
        queue_word(OP_FREE,        3'd2, 3'd2, 4'd15, 1'b0, 32'h0);
        queue_word(OP_FREE,        3'd1, 3'd3, 4'd8,  1'b0, 32'h0);
        queue_word(OP_ALLOC,       3'd1, 3'd3, 4'd0,  1'b0, 32'h0);
        queue_word(OP_FREE,        3'd3, 3'd1, 4'd0,  1'b0, 32'h0);
        queue_word(OP_COUNT_OWNED, 3'd4, 3'd0, 4'd1,  1'b0, 32'h0);
        queue_word(OP_ALLOC,       3'd0, 3'd7, 4'd2,  1'b0, 32'h0);
        queue_word(OP_COUNT_FREE,  3'd7, 3'd0, 4'd0,  1'b1, 32'h0);
        queue_word(OP_FREE,        3'd5, 3'd5, 4'd9,  1'b1, 32'h0);
        queue_word(OP_RAW_READ,    3'd0, 3'd0, 4'd0,  1'b0, 32'h0);
        queue_word(OP_RAW_READ,    3'd0, 3'd0, 4'd0,  1'b1, 32'h0);
        queue_word(OP_RAW_WRITE,   3'd0, 3'd0, 4'd0,  1'b0, 32'hffff_ffff);
        queue_word(OP_COUNT_FREE,  3'd0, 3'd0, 4'd0,  1'b0, 32'h0);
        queue_word(OP_ALLOC,       3'd0, 3'd1, 4'd1,  1'b0, 32'h0);
        queue_word(OP_RAW_WRITE,   3'd0, 3'd0, 4'd0,  1'b1, 32'h9bdf_8ace);
        queue_word(OP_FREE,        3'd1, 3'd2, 4'd8,  1'b0, 32'h0);
        queue_word(OP_UNUSED_LO,   3'd7, 3'd7, 4'd15, 1'b1, 32'hffff_ffff);
        queue_word(OP_UNUSED_HI,   3'd3, 3'd3, 4'd8,  1'b0, 32'h0);
        queue_word(OP_RAW_WRITE,   3'd0, 3'd0, 4'd0,  1'b0, 32'h0);
        repeat (RANDOM_WORDS) begin
            pending_words.push_back(random_word());
            total_words++;
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_words < total_words || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d words: %0d allocate, %0d free, %0d count, %0d raw, %0d unused.",
                 accepted_words, op_hits[OP_ALLOC], op_hits[OP_FREE],
                 op_hits[OP_COUNT_OWNED] + op_hits[OP_COUNT_FREE],
                 op_hits[OP_RAW_READ] + op_hits[OP_RAW_WRITE],
                 op_hits[OP_UNUSED_LO] + op_hits[OP_UNUSED_HI]);
        $display({"Checked %0d results with %0d short fills and %0d invalid requests; ",
                  "%0d mismatches."},
                 checked_results, short_fills, invalid_requests, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/rbma_pkg.sv
rtl/rbma_front.sv
rtl/rbma_queue.sv
rtl/rbma_back.sv
rtl/read_buffer_map_allocator_top.sv
rtl/rbma_checker.sv
bench/read_buffer_map_allocator_top_tb.sv
